// ===== rtl/dkc_pkg.sv =====
// ----------------------------------------------------------------------------
// dkc_pkg
// Shared constants, types and the base decoder for the distinct k-mer counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dkc_pkg;

   // Field widths of the channels and the length register.
   localparam int COUNT_W = 21;
   localparam int BYTE_W  = 8;
   localparam int KLEN_W  = 4;

   localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;

   // Case folding: bytes above the limit lose the offset.
   localparam logic [BYTE_W-1:0] FOLD_LIMIT  = 8'd90;
   localparam logic [BYTE_W-1:0] FOLD_OFFSET = 8'd32;

   // Upper-case nucleotide characters.
   localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;

   // Two-bit base codes.
   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // Width of the sequence tag kept with every bitmap row.
   localparam int EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } base_type;

   // Control of one item as it moves from the window stage to the tally stage.
   typedef struct packed {
      logic last;
      logic win;
   } item_ctl_type;

   // Fold the byte to upper case and map it to a base code.
   function automatic base_type base_decode(input logic [BYTE_W-1:0] raw);
      logic [BYTE_W-1:0] folded;
      base_type          res;
      folded    = (raw > FOLD_LIMIT) ? raw - FOLD_OFFSET : raw;
      res.valid = 1'b1;
      res.code  = BASE_A;
      case (folded)
         CHAR_A: res.code = BASE_A;
         CHAR_C: res.code = BASE_C;
         CHAR_G: res.code = BASE_G;
         CHAR_T: res.code = BASE_T;
         default: begin
            res.valid = 1'b0;
            res.code  = BASE_A;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dkc_channels.sv =====
// ----------------------------------------------------------------------------
// dkc channels
// Valid/ready channel interfaces for sequence bytes and count results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dkc_req_if;
   logic                       valid;
   logic                       ready;
   logic [dkc_pkg::BYTE_W-1:0] base_byte;
   logic                       last_byte;

   modport source (output valid, output base_byte, output last_byte, input ready);
   modport sink   (input valid, input base_byte, input last_byte, output ready);
endinterface

interface dkc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dkc_pkg::COUNT_W-1:0] distinct_count;

   modport source (output valid, output distinct_count, input ready);
   modport sink   (input valid, input distinct_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/distinct_kmer_counter_unit.sv =====
// ----------------------------------------------------------------------------
// distinct_kmer_counter_unit
// Counts the distinct k-mers of a nucleotide sequence streamed one byte per
// item, using a presence bitmap held in RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  req_chan  in         valid/ready        base_byte[7:0], last_byte
//  rsp_chan  out        valid/ready        distinct_count[20:0]
//  csr_*     in         write enable only  csr_write_data[3:0] = kmer_length
//
//  One byte is accepted per cycle while input is not held off: its bitmap row is read
//  at accept and written back from the row stage, with a forwarding register for
//  back-to-back hits. The count is registered once the final byte leaves the row stage.
//  After reset and after every 255th sequence, a clearing pass writes the bitmap one row
//  a cycle (2**(2*K_MAX-6) rows for K_MAX >= 4, 16384 at K_MAX=10) with input held off.
//  Input also stalls while a final byte waits on a full result register or a tag wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_kmer_counter_unit #(
   parameter int K_MAX = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dkc_req_if.sink                         req_chan,
   dkc_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_write_en,
   input  wire logic [dkc_pkg::KLEN_W-1:0] csr_write_data
);

   logic                  acc_valid;
   logic                  ready;
   dkc_pkg::item_ctl_type win_ctl;
   logic [2*K_MAX-1:0]    win_index;

   // An item is taken when both sides agree.
   assign acc_valid      = req_chan.valid && ready;
   assign req_chan.ready = ready;

   dkc_window #(
      .K_MAX (K_MAX)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .acc_valid      (acc_valid),
      .base_byte      (req_chan.base_byte),
      .last_byte      (req_chan.last_byte),
      .win_ctl        (win_ctl),
      .win_index      (win_index)
   );

   dkc_tally #(
      .K_MAX (K_MAX)
   ) u_tally (
      .clock     (clock),
      .reset     (reset),
      .acc_valid (acc_valid),
      .acc_ctl   (win_ctl),
      .acc_index (win_index),
      .req_ready (ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_count (rsp_chan.distinct_count)
   );

endmodule

`default_nettype wire

// ===== rtl/dkc_ram.sv =====
// ----------------------------------------------------------------------------
// dkc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read share the clock; a read of the entry being written sees old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dkc_window.sv =====
// ----------------------------------------------------------------------------
// dkc_window
// Base decoding, rolling k-mer index, run length and the k-mer length register.
// ----------------------------------------------------------------------------
`default_nettype none

module dkc_window #(
   parameter int K_MAX = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic [dkc_pkg::KLEN_W-1:0]  csr_write_data,
   input  wire logic                        acc_valid,
   input  wire logic [dkc_pkg::BYTE_W-1:0]  base_byte,
   input  wire logic                        last_byte,
   output      dkc_pkg::item_ctl_type       win_ctl,
   output      logic [2*K_MAX-1:0]          win_index
);

   localparam int IDX_W = 2 * K_MAX;
   localparam int KW    = $clog2(K_MAX + 1);

   logic [dkc_pkg::KLEN_W-1:0] kmer_length_ff, kmer_length_in;
   logic [IDX_W-1:0]           rolling_ff, rolling_in;
   logic [KW-1:0]              run_ff, run_in;

   logic [KW-1:0]              k_eff;
   dkc_pkg::base_type          base;
   logic [IDX_W-1:0]           rolling_upd;
   logic [KW-1:0]              run_upd;
   logic [IDX_W-1:0]           mask;

   // Clamp the programmed length into 1..K_MAX.
   always_comb begin
      if (kmer_length_ff == '0) begin
         k_eff = KW'(1);
      end else if ({1'b0, kmer_length_ff} > 5'(K_MAX)) begin
         k_eff = KW'(K_MAX);
      end else begin
         k_eff = KW'(kmer_length_ff);
      end
   end

   // Shift the new base in and count the run of valid bases.
   always_comb begin
      base        = dkc_pkg::base_decode(base_byte);
      rolling_upd = IDX_W'({rolling_ff, base.code});
      if (!base.valid) begin
         run_upd = '0;
      end else if (run_ff < k_eff) begin
         run_upd = KW'(run_ff + 1'b1);
      end else begin
         run_upd = run_ff;
      end
      mask = ~({IDX_W{1'b1}} << {k_eff, 1'b0});
   end

   // The window of the current item.
   always_comb begin
      win_ctl.last = last_byte;
      win_ctl.win  = base.valid && (run_upd >= k_eff);
      win_index    = rolling_upd & mask;
   end

   // Next state: a final byte clears the sequence state.
   always_comb begin
      kmer_length_in = csr_write_en ? csr_write_data : kmer_length_ff;
      rolling_in     = rolling_ff;
      run_in         = run_ff;
      if (acc_valid) begin
         if (last_byte) begin
            rolling_in = '0;
            run_in     = '0;
         end else begin
            rolling_in = base.valid ? rolling_upd : rolling_ff;
            run_in     = run_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= dkc_pkg::KLEN_RESET;
         rolling_ff     <= '0;
         run_ff         <= '0;
      end else begin
         kmer_length_ff <= kmer_length_in;
         rolling_ff     <= rolling_in;
         run_ff         <= run_in;
      end
   end

   // Assertions.
   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff <= KW'(K_MAX))
      else $error("run length exceeds the largest k-mer length");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      acc_valid && last_byte |=> run_ff == '0 && rolling_ff == '0)
      else $error("sequence state not cleared after a final byte");

endmodule

`default_nettype wire

// ===== rtl/dkc_tally.sv =====
// ----------------------------------------------------------------------------
// dkc_tally
// Bitmap read-modify-write with forwarding, distinct count, sequence tags,
// the clearing pass and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dkc_tally #(
   parameter int K_MAX = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        acc_valid,
   input  wire dkc_pkg::item_ctl_type       acc_ctl,
   input  wire logic [2*K_MAX-1:0]          acc_index,
   output      logic                        req_ready,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [dkc_pkg::COUNT_W-1:0] rsp_count
);

   localparam int IDX_W     = 2 * K_MAX;
   localparam int ROW_SEL_W = (IDX_W > 6) ? 6 : IDX_W / 2;
   localparam int ROW_BITS  = 1 << ROW_SEL_W;
   localparam int ADDR_W    = IDX_W - ROW_SEL_W;
   localparam int DEPTH     = 1 << ADDR_W;
   localparam int RAM_W     = ROW_BITS + dkc_pkg::EPOCH_W;

   // Stage registers of the item whose bitmap row is being read.
   logic                          s1_valid_ff, s1_valid_in;
   dkc_pkg::item_ctl_type         s1_ctl_ff, s1_ctl_in;
   logic [ADDR_W-1:0]             s1_row_ff, s1_row_in;
   logic [ROW_SEL_W-1:0]          s1_sel_ff, s1_sel_in;

   // Last row written, for a read that raced the write.
   logic                          fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]             fwd_row_ff, fwd_row_in;
   logic [ROW_BITS-1:0]           fwd_bits_ff, fwd_bits_in;

   logic [dkc_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic [dkc_pkg::EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic                          clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0]             clear_cnt_ff, clear_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dkc_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                          ram_wr_en;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [RAM_W-1:0]              ram_wr_data;
   logic                          ram_rd_en;
   logic [RAM_W-1:0]              ram_rd_data;

   logic [ROW_BITS-1:0]           row_cur;
   logic [ROW_BITS-1:0]           row_new;
   logic                          hit;
   logic                          s1_go;
   logic                          seq_end;
   logic [dkc_pkg::COUNT_W-1:0]   total_next;

   dkc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (acc_index[IDX_W-1:ROW_SEL_W]),
      .rd_data (ram_rd_data)
   );

   // A window item reads its row as it is accepted.
   assign ram_rd_en = acc_valid && acc_ctl.win;

   // Current row: forwarded write, else the RAM row if its tag is this sequence's.
   always_comb begin
      if (fwd_valid_ff && (fwd_row_ff == s1_row_ff)) begin
         row_cur = fwd_bits_ff;
      end else if (ram_rd_data[RAM_W-1:ROW_BITS] == epoch_ff) begin
         row_cur = ram_rd_data[ROW_BITS-1:0];
      end else begin
         row_cur = '0;
      end
      row_new    = row_cur | (ROW_BITS'(1) << s1_sel_ff);
      hit        = s1_ctl_ff.win && !row_cur[s1_sel_ff];
      total_next = total_ff + dkc_pkg::COUNT_W'(hit);
   end

   // A final item waits while the result register is still full.
   assign s1_go   = s1_valid_ff && !(s1_ctl_ff.last && rsp_valid_ff && !rsp_ready);
   assign seq_end = s1_go && s1_ctl_ff.last;

   // Hold off input during a clearing pass, a stall, and before a tag wrap.
   assign req_ready = !clear_busy_ff && !(s1_valid_ff && !s1_go) &&
                      !(s1_valid_ff && s1_ctl_ff.last && (epoch_ff == dkc_pkg::EPOCH_LAST));

   // RAM write: the clearing pass owns the port while it runs.
   always_comb begin
      if (clear_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_go && hit;
         ram_wr_addr = s1_row_ff;
         ram_wr_data = {epoch_ff, row_new};
      end
   end

   // Next state of the stage, the count, the tags and the result.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_ctl_in     = s1_ctl_ff;
      s1_row_in     = s1_row_ff;
      s1_sel_in     = s1_sel_ff;
      fwd_valid_in  = fwd_valid_ff;
      fwd_row_in    = fwd_row_ff;
      fwd_bits_in   = fwd_bits_ff;
      total_in      = total_ff;
      epoch_in      = epoch_ff;
      clear_busy_in = clear_busy_ff;
      clear_cnt_in  = clear_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_count_in  = rsp_count_ff;

      if (acc_valid) begin
         s1_valid_in = 1'b1;
         s1_ctl_in   = acc_ctl;
         s1_row_in   = acc_index[IDX_W-1:ROW_SEL_W];
         s1_sel_in   = acc_index[ROW_SEL_W-1:0];
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      if (s1_go && hit) begin
         fwd_valid_in = 1'b1;
         fwd_row_in   = s1_row_ff;
         fwd_bits_in  = row_new;
      end

      if (s1_go) begin
         total_in = total_next;
      end

      // End of a sequence: emit the count and move to a fresh tag.
      if (seq_end) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = total_next;
         total_in     = '0;
         fwd_valid_in = 1'b0;
         if (epoch_ff == dkc_pkg::EPOCH_LAST) begin
            epoch_in      = dkc_pkg::EPOCH_FIRST;
            clear_busy_in = 1'b1;
            clear_cnt_in  = '0;
         end else begin
            epoch_in = epoch_ff + 1'b1;
         end
      end

      // Clearing pass, one row per cycle.
      if (clear_busy_ff) begin
         clear_cnt_in = ADDR_W'(clear_cnt_ff + 1'b1);
         if (clear_cnt_ff == {ADDR_W{1'b1}}) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         total_ff      <= '0;
         epoch_ff      <= dkc_pkg::EPOCH_FIRST;
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         total_ff      <= total_in;
         epoch_ff      <= epoch_in;
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff    <= s1_ctl_in;
      s1_row_ff    <= s1_row_in;
      s1_sel_ff    <= s1_sel_in;
      fwd_row_ff   <= fwd_row_in;
      fwd_bits_ff  <= fwd_bits_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   // Assertions.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !acc_valid && !s1_valid_ff)
      else $error("item in flight during the clearing pass");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |-> !acc_valid)
      else $error("item accepted while the row stage is stalled");

   a_result_on_end: assert property (@(posedge clock) disable iff (reset)
      seq_end |=> rsp_valid_ff && total_ff == '0)
      else $error("sequence end did not load the result and clear the count");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("sequence tag matches the cleared-row tag");

endmodule

`default_nettype wire

// ===== dv/distinct_count_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Distinct k-mer count checker
// Watches the byte, count and length-register ports of the counter, keeps its
// own presence bitmap and rolling base history, and compares every count that
// the block returns with the oldest predicted one.
// ----------------------------------------------------------------------------

module distinct_count_checker #(
   parameter int K_MAX = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dkc_req_if                              req_chan,
   dkc_rsp_if                              rsp_chan,
   input  wire logic                       csr_write_en,
   input  wire logic [dkc_pkg::KLEN_W-1:0] csr_write_data,
   output int                              mismatch_count,
   output int                              counts_seen,
   output int                              counts_waiting
);

   import dkc_pkg::*;

   localparam int INDEX_W      = 2 * K_MAX;
   localparam int REPORT_LIMIT = 10;

   // Letters in base-code order, so the position of a match is its code.
   localparam logic [BYTE_W-1:0] LETTERS [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

   // Predicted sequence state.
   logic [KLEN_W-1:0]  kmer_len;
   logic [INDEX_W-1:0] base_history;
   int unsigned        run_length;
   logic [COUNT_W-1:0] distinct_so_far;
   bit                 kmer_seen [2**INDEX_W];
   logic [INDEX_W-1:0] marked_windows [$];
   logic [COUNT_W-1:0] expected_counts [$];

   int mismatches = 0;
   int checked    = 0;

   // Drop everything that belongs to the current sequence. Only the marked
   // bitmap entries are cleared, which keeps a sequence end cheap.
   function automatic void forget_sequence();
      foreach (marked_windows[i])
         kmer_seen[marked_windows[i]] = 1'b0;
      marked_windows.delete();
      base_history    = '0;
      run_length      = 0;
      distinct_so_far = '0;
   endfunction

   // Fold one byte, extend the window and mark the k-mer it completes.
   // The final byte of a sequence is counted before its total is queued.
   function automatic void tally_base_byte(input logic [BYTE_W-1:0] raw,
                                           input logic is_last);
      logic [BYTE_W-1:0]  upper;
      logic [1:0]         code;
      logic               is_base;
      int unsigned        k_eff;
      logic [INDEX_W-1:0] window;
      upper   = (raw > FOLD_LIMIT) ? raw - FOLD_OFFSET : raw;
      is_base = 1'b0;
      code    = BASE_A;
      for (int c = 0; c < 4; c++) begin
         if (upper == LETTERS[c]) begin
            is_base = 1'b1;
            code    = 2'(c);
         end
      end
      // A length of zero behaves as one, anything above the maximum as the maximum.
      if (kmer_len == '0)
         k_eff = 1;
      else if (kmer_len > K_MAX)
         k_eff = K_MAX;
      else
         k_eff = 32'(kmer_len);
      if (is_base) begin
         base_history = {base_history[INDEX_W-3:0], code};
         if (run_length < k_eff)
            run_length++;
         if (run_length >= k_eff) begin
            window = base_history & ({INDEX_W{1'b1}} >> (INDEX_W - 2 * k_eff));
            if (!kmer_seen[window]) begin
               kmer_seen[window] = 1'b1;
               marked_windows.push_back(window);
               distinct_so_far++;
            end
         end
      end else begin
         run_length = 0;
      end
      if (is_last) begin
         expected_counts.push_back(distinct_so_far);
         forget_sequence();
      end
   endfunction

   // Sample all ports at the rising edge. A count is checked before the byte
   // of the same edge is absorbed, so no count can match its own final byte.
   always @(posedge clock) begin
      logic [COUNT_W-1:0] wanted;
      if (reset) begin
         kmer_len = KLEN_RESET;
         forget_sequence();
         expected_counts.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            checked++;
            if (expected_counts.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: distinct count %0d arrived with none expected",
                           $time, rsp_chan.distinct_count);
            end else begin
               wanted = expected_counts.pop_front();
               if (rsp_chan.distinct_count !== wanted) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: distinct count of result %0d: expected %0d, actual %0d",
                              $time, checked, wanted, rsp_chan.distinct_count);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            tally_base_byte(req_chan.base_byte, req_chan.last_byte);
         if (csr_write_en)
            kmer_len = csr_write_data;
      end
      mismatch_count <= mismatches;
      counts_seen    <= checked;
      counts_waiting <= expected_counts.size();
   end

endmodule

// ===== dv/distinct_kmer_counter_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Distinct k-mer counter testbench
// Streams directed and random nucleotide sequences through the counter under
// a range of k-mer lengths, with sender gaps, receiver stalls, a long receiver
// hold-off and bursts of one-byte sequences that cross the bitmap tag wrap.
// The checker beside the block predicts and compares every count.
// ----------------------------------------------------------------------------

module distinct_kmer_counter_unit_test;

   import dkc_pkg::*;

   localparam int K_MAX          = 10;
   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int NUM_PHASES     = 16;
   localparam int PHASE_ITEMS    = 95;
   localparam int SHORT_PHASE    = 6;
   localparam int SHORT_ITEMS    = 300;
   localparam int PRESSURE_PHASE = 10;
   localparam int PRESSURE_ITEMS = 60;
   localparam int HOLD_CYCLES    = 400;
   localparam int MOTIF_MAX      = 6;

   localparam logic [KLEN_W-1:0] KLEN_EXTREMES [4] = '{4'd0, 4'd15, 4'd1, 4'd10};

   typedef enum int {STYLE_UNIFORM, STYLE_PAIR, STYLE_MOTIF, STYLE_NOISY} seq_style_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_en;
   logic [KLEN_W-1:0] csr_write_data;

   dkc_req_if req_chan ();
   dkc_rsp_if rsp_chan ();

   int mismatch_count;
   int counts_seen;
   int counts_waiting;

   // Sender bookkeeping.
   int unsigned items_sent    = 0;
   int unsigned counts_due    = 0;
   int unsigned burst_left    = 0;
   int unsigned settings_used = 0;
   bit          sender_gaps   = 1'b0;

   // Receiver long hold-off requests and how many have been served.
   int unsigned stall_asks  = 0;
   int unsigned stalls_done = 0;

   // State of the random sequence being generated.
   int unsigned   seq_left = 0;
   int unsigned   seq_pos  = 0;
   int unsigned   motif_len;
   seq_style_type seq_style;
   logic [1:0]    motif [MOTIF_MAX];
   logic [3:0]    pair_codes;

   int unsigned cycles_run = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   distinct_kmer_counter_unit #(
      .K_MAX(K_MAX)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   distinct_count_checker #(
      .K_MAX(K_MAX)
   ) tally_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .counts_seen   (counts_seen),
      .counts_waiting(counts_waiting)
   );

   // Letter for a base code, in lower case one time in three.
   function automatic logic [BYTE_W-1:0] letter_for(input logic [1:0] code);
      logic [BYTE_W-1:0] letter;
      case (code)
         BASE_A: letter = CHAR_A;
         BASE_C: letter = CHAR_C;
         BASE_G: letter = CHAR_G;
         default: letter = CHAR_T;
      endcase
      if ($urandom_range(0, 2) == 0)
         letter = letter + FOLD_OFFSET;
      return letter;
   endfunction

   // Offer one item and wait for its acceptance. With gaps enabled the
   // sender works in bursts separated by idle stretches of random length.
   task automatic send_item(input logic [BYTE_W-1:0] value, input logic is_last);
      int unsigned roll;
      int unsigned gap;
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 64);
         roll       = $urandom_range(0, 9);
         if (roll < 6)
            gap = $urandom_range(0, 3);
         else if (roll < 9)
            gap = $urandom_range(4, 12);
         else
            gap = $urandom_range(13, 40);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left != 0)
         burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.base_byte <= value;
      req_chan.last_byte <= is_last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      items_sent++;
      if (is_last)
         counts_due++;
   endtask

   // Send a string byte by byte, optionally closing the sequence on its end.
   task automatic send_text(input string text, input bit closes);
      for (int i = 0; i < text.len(); i++)
         send_item(text[i], closes && (i == text.len() - 1));
   endtask

   // Stop offering, wait until every count is back, then let the pipeline
   // drain bytes that carry no count.
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (counts_seen != counts_due)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_kmer_length(input logic [KLEN_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // Next byte of the random sequence stream. Most sequences are mostly
   // bases, drawn uniformly, from a two-letter alphabet or from a repeated
   // motif, so that windows recur; a few are noisy.
   task automatic send_random_base_byte();
      int unsigned       roll;
      logic [1:0]        code;
      logic [BYTE_W-1:0] value;
      if (seq_left == 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            seq_left = $urandom_range(1, 3);
         else if (roll < 80)
            seq_left = $urandom_range(4, 40);
         else
            seq_left = $urandom_range(41, 200);
         seq_style  = seq_style_type'($urandom_range(0, 3));
         motif_len  = $urandom_range(1, MOTIF_MAX);
         pair_codes = 4'($urandom);
         foreach (motif[i])
            motif[i] = 2'($urandom_range(0, 3));
         seq_pos = 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < ((seq_style == STYLE_NOISY) ? 30 : 3)) begin
         value = 8'($urandom_range(0, 255));
      end else begin
         case (seq_style)
            STYLE_PAIR: begin
               code = ($urandom_range(0, 1) == 0) ? pair_codes[1:0] : pair_codes[3:2];
            end
            STYLE_MOTIF: begin
               code = (roll < 8) ? 2'($urandom_range(0, 3)) : motif[seq_pos % motif_len];
            end
            default: begin
               code = 2'($urandom_range(0, 3));
            end
         endcase
         value = letter_for(code);
      end
      seq_pos++;
      seq_left--;
      send_item(value, seq_left == 0);
   endtask

   // Receiver: cycles through always ready, light stalls, heavy stalls and a
   // fixed pattern, and serves each long hold-off request in its own count.
   initial begin : receiver
      int unsigned rx_cycle;
      logic        take;
      rx_cycle = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (stalls_done != stall_asks) begin
            stalls_done++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         case ((rx_cycle >> 9) % 4)
            0: take = 1'b1;
            1: take = ($urandom_range(0, 3) != 0);
            2: take = ($urandom_range(0, 3) == 0);
            default: take = ((rx_cycle % 7) < 3);
         endcase
         rsp_chan.ready <= take;
      end
   end

   // Cycle counter that ends a run which hangs.
   initial begin : watchdog
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("Run stopped after %0d cycles.", cycles_run);
      $display("distinct_kmer_counter_unit_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned       roll;
      logic [KLEN_W-1:0] phase_klen;
      logic [BYTE_W-1:0] value;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.base_byte <= '0;
      req_chan.last_byte <= 1'b0;
      csr_write_en       <= 1'b0;
      csr_write_data     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed sequences at the reset length of four. A sequence shorter
      // than k, both cases of every base with a repeated window, bytes that
      // break the run (zero, all ones, high bytes that fold to lower case,
      // the fold limit itself), and a sequence ending on a non-base byte.
      send_text("A", 1'b1);
      send_text("ACGTacgT", 1'b1);
      send_item(8'h00, 1'b0);
      send_text("cat", 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h81, 1'b0);
      send_item(FOLD_LIMIT, 1'b0);
      send_text("ttttt", 1'b1);
      send_text("GGGG", 1'b0);
      send_item(8'h80, 1'b1);

      // Random phases. Each phase starts from an idle block with a new
      // length; a sequence left open across the boundary sees the change.
      sender_gaps = 1'b1;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         roll = $urandom_range(0, 99);
         if (phase < 4)
            phase_klen = KLEN_EXTREMES[phase];
         else if (roll < 15)
            phase_klen = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(11, 15));
         else
            phase_klen = 4'($urandom_range(1, K_MAX));
         settle_block();
         write_kmer_length(phase_klen);
         if (phase == SHORT_PHASE) begin
            // One-byte sequences, enough to pass the bitmap tag wrap.
            repeat (SHORT_ITEMS) begin
               value = ($urandom_range(0, 9) < 6) ? letter_for(2'($urandom_range(0, 3)))
                                                  : 8'($urandom_range(0, 255));
               send_item(value, 1'b1);
            end
            seq_left = 0;
         end else if (phase == PRESSURE_PHASE) begin
            // Back-to-back short sequences against a receiver held off.
            sender_gaps = 1'b0;
            stall_asks <= stall_asks + 1;
            repeat (PRESSURE_ITEMS)
               send_item(letter_for(2'($urandom_range(0, 3))), $urandom_range(0, 2) != 0);
            seq_left    = 0;
            sender_gaps = 1'b1;
         end else begin
            repeat (PHASE_ITEMS) send_random_base_byte();
         end
      end

      settle_block();
      $display("Run covered %0d sequence bytes in %0d sequences over %0d length settings.",
               items_sent, counts_due, settings_used);
      $display("%0d counts checked, %0d mismatched, %0d still expected.",
               counts_seen, mismatch_count, counts_waiting);
      if (mismatch_count == 0 && counts_waiting == 0)
         $display("distinct_kmer_counter_unit_test: PASS");
      else
         $display("distinct_kmer_counter_unit_test: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dkc_pkg.sv
rtl/dkc_channels.sv
rtl/dkc_ram.sv
rtl/dkc_window.sv
rtl/dkc_tally.sv
rtl/distinct_kmer_counter_unit.sv
dv/distinct_count_checker.sv
dv/distinct_kmer_counter_unit_test.sv
